### rtl/adsr_pkg.sv
// adsr_pkg: shared types and constants of the linear ADSR envelope generator
// phase codes, event kinds, register indexes, field widths and register reset values
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

	// field widths fixed by the register and stream layout
	localparam int LEN_W     = 24;
	localparam int SUS_W     = 16;
	localparam int STEP_W    = 16;
	localparam int LEVEL_W   = 16;
	localparam int CFG_IDX_W = 3;

	typedef logic [1:0] phase_t;
	typedef logic [1:0] mode_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// envelope phases
	localparam phase_t PH_ATTACK  = 2'd0;
	localparam phase_t PH_DECAY   = 2'd1;
	localparam phase_t PH_SUSTAIN = 2'd2;
	localparam phase_t PH_RELEASE = 2'd3;

	// event kinds
	localparam mode_t MODE_TICK    = 2'd0;
	localparam mode_t MODE_NOTEOFF = 2'd1;
	localparam mode_t MODE_RESTART = 2'd2;

	// register indexes
	localparam cfg_idx_t REG_ATTACK  = 3'd0;
	localparam cfg_idx_t REG_DECAY   = 3'd1;
	localparam cfg_idx_t REG_SUSTAIN = 3'd2;
	localparam cfg_idx_t REG_RELEASE = 3'd3;
	localparam cfg_idx_t REG_STEP    = 3'd4;

	// register reset values
	localparam logic [LEN_W-1:0]  RST_ATTACK  = 24'd10000;
	localparam logic [LEN_W-1:0]  RST_DECAY   = 24'd10000;
	localparam logic [SUS_W-1:0]  RST_SUSTAIN = 16'd19661;
	localparam logic [LEN_W-1:0]  RST_RELEASE = 24'd400000;
	localparam logic [STEP_W-1:0] RST_STEP    = 16'd21;

endpackage

`default_nettype wire

### rtl/adsr_div.sv
// adsr_div: restoring bit-serial divider, one quotient bit per cycle
// the caller guarantees the quotient fits QW bits (top LEN_W numerator bits below den)
// depends on adsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module adsr_div
	import adsr_pkg::*;
#(
	parameter int QW = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [LEN_W+QW-1:0]   num,
	input  wire logic [LEN_W-1:0]      den,
	output logic                       done,
	output logic [QW-1:0]              quot
);

	localparam int CNT_W = $clog2(QW + 1);

	logic [LEN_W-1:0] rem_q;
	logic [QW-1:0]    quo_q;
	logic [LEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [LEN_W:0]   r2;
	logic [LEN_W+1:0] diff;
	logic             ge;

	// shared trial subtract
	always_comb begin
		r2   = {rem_q, quo_q[QW-1]};
		diff = {1'b0, r2} - {2'b00, den_q};
		ge   = !diff[LEN_W+1];
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= num[LEN_W+QW-1:QW];
			quo_q <= num[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LEN_W-1:0] : r2[LEN_W-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				cnt_q  <= CNT_W'(QW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

### rtl/adsr_envelope_generator.sv
// adsr_envelope_generator: linear ADSR envelope, one result word per event word
// tick with a division: the phase walk, the multiply, then the bit-serial divider in adsr_div, then
// the level commit; ticks in sustain or past the end of release skip the multiply and divide
// note-off, restart and no-op go straight to the done state; the next word is accepted only once
// the block is back in idle after the result is registered; a stalled result holds the block
// reset: async active low; attack phase, zero elapsed and level, registers at defaults
`timescale 1ns / 1ps
`default_nettype none

module adsr_envelope_generator
	import adsr_pkg::*;
#(
	parameter int LEVEL_FRAC_BITS = 15,
	parameter int TIME_BITS       = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// event words
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [7:0]           s_axis_tdata,   // [1:0] restart_phase
	input  wire logic [1:0]           s_axis_tuser,   // [1:0] mode
	// result words
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [23:0]               m_axis_tdata,   // [15:0] level, [17:16] phase, [18] released
	// register writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LEN_W-1:0]     cfg_data
);

	localparam int LW    = LEVEL_FRAC_BITS + 1;
	localparam int CW    = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W;
	localparam int NUM_W = LW + LEN_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WALK   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DIVGO  = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]           state_q;
	logic [LEN_W-1:0]     attack_q, decay_q, release_q;
	logic [SUS_W-1:0]     sustain_q;
	logic [STEP_W-1:0]    step_q;
	phase_t               phase_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [LW-1:0]        mul_a_q;
	logic [LW-1:0]        lvl_q;
	logic [NUM_W-1:0]     num_q;
	logic                 m_valid_q;
	logic [LEVEL_W-1:0]   out_level_q;
	phase_t               out_phase_q;
	logic                 out_rel_q;

	logic [LW-1:0]        one_w;
	logic [LW+15:0]       sus_ext, one_ext;
	logic [LW-1:0]        s_w;
	logic [LEN_W-1:0]     len_sel;
	logic [CW:0]          diff;
	logic                 e_lt;
	logic [LW-1:0]        mul_sel;
	logic                 div_done;
	logic [LW-1:0]        quot;
	logic [LW+15:0]       lvl_ext;
	logic [TIME_BITS:0]   e_sum;
	logic                 released;
	logic                 in_acc;
	logic                 out_free;
	mode_t                in_mode;
	phase_t               in_rp;

	assign in_mode  = s_axis_tuser;
	assign in_rp    = s_axis_tdata[1:0];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;

	// full scale and clamped sustain
	always_comb begin
		one_w   = LW'(1) << LEVEL_FRAC_BITS;
		sus_ext = (LW + 16)'(sustain_q);
		one_ext = (LW + 16)'(one_w);
		s_w     = (sus_ext > one_ext) ? one_w : sus_ext[LW-1:0];
	end

	// phase length and multiplier operand select
	always_comb begin
		case (phase_q)
			PH_ATTACK: begin
				len_sel = attack_q;
				mul_sel = one_w;
			end
			PH_DECAY: begin
				len_sel = decay_q;
				mul_sel = one_w - s_w;
			end
			PH_RELEASE: begin
				len_sel = release_q;
				mul_sel = s_w;
			end
			default: begin
				len_sel = attack_q;
				mul_sel = s_w;
			end
		endcase
	end

	// elapsed against phase length, shared compare and subtract
	always_comb begin
		diff = {1'b0, CW'(elapsed_q)} - {1'b0, CW'(len_sel)};
		e_lt = diff[CW];
	end

	// level and elapsed update terms
	always_comb begin
		lvl_ext  = (LW + 16)'(lvl_q);
		e_sum    = {1'b0, elapsed_q} + (TIME_BITS + 1)'(step_q);
		released = (phase_q == PH_RELEASE) && (CW'(release_q) <= CW'(elapsed_q));
	end

	adsr_div #(
		.QW(LW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == ST_DIVGO),
		.num   (num_q),
		.den   (len_sel),
		.done  (div_done),
		.quot  (quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= RST_ATTACK;
			decay_q   <= RST_DECAY;
			sustain_q <= RST_SUSTAIN;
			release_q <= RST_RELEASE;
			step_q    <= RST_STEP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ATTACK:  attack_q  <= cfg_data;
				REG_DECAY:   decay_q   <= cfg_data;
				REG_SUSTAIN: sustain_q <= cfg_data[SUS_W-1:0];
				REG_RELEASE: release_q <= cfg_data;
				REG_STEP:    step_q    <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_ATTACK;
			elapsed_q <= '0;
			level_q   <= '0;
			mul_a_q   <= '0;
			lvl_q     <= '0;
			num_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_mode)
							MODE_TICK: state_q <= ST_WALK;
							MODE_NOTEOFF: begin
								if (phase_q != PH_RELEASE) begin
									phase_q   <= PH_RELEASE;
									elapsed_q <= '0;
								end
								state_q <= ST_DONE;
							end
							MODE_RESTART: begin
								phase_q   <= in_rp;
								elapsed_q <= '0;
								state_q   <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				// fall through phases, one per cycle
				ST_WALK: begin
					if (phase_q == PH_SUSTAIN) begin
						lvl_q   <= s_w;
						state_q <= ST_FINISH;
					end else if (e_lt) begin
						mul_a_q <= mul_sel;
						state_q <= ST_MUL;
					end else if (phase_q == PH_RELEASE) begin
						lvl_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						elapsed_q <= diff[TIME_BITS-1:0];
						phase_q   <= (phase_q == PH_ATTACK) ? PH_DECAY : PH_SUSTAIN;
					end
				end
				ST_MUL: begin
					num_q   <= NUM_W'(mul_a_q) * NUM_W'(LEN_W'(elapsed_q));
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						case (phase_q)
							PH_ATTACK: lvl_q <= quot;
							PH_DECAY:  lvl_q <= one_w - quot;
							default:   lvl_q <= s_w - quot;
						endcase
						state_q <= ST_FINISH;
					end
				end
				// commit level, advance elapsed with saturation
				ST_FINISH: begin
					level_q   <= lvl_ext[LEVEL_W-1:0];
					elapsed_q <= e_sum[TIME_BITS] ? '1 : e_sum[TIME_BITS-1:0];
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_level_q <= level_q;
			out_phase_q <= phase_q;
			out_rel_q   <= released;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b0, out_rel_q, out_phase_q, out_level_q};

endmodule

`default_nettype wire

### tb/adsr_envelope_generator_test.sv
// adsr_envelope_generator_test: self-checking bench for the linear ADSR envelope generator
// drives event words and register writes, predicts every result word and compares it
// depends on adsr_pkg and adsr_envelope_generator
`timescale 1ns / 1ps

module adsr_envelope_generator_test;
	import adsr_pkg::*;

	localparam int FRAC_BITS = 15;
	localparam int TIME_W = 24;
	localparam logic [63:0] ELAPSED_MAX = (64'd1 << TIME_W) - 64'd1;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	// the fourth event kind does nothing but report the state
	localparam mode_t MODE_IDLE = 2'd3;

	typedef struct packed {
		logic               released;
		phase_t             phase;
		logic [LEVEL_W-1:0] level;
	} env_word_t;

	// envelope state tracker and store of expected result words
	class envelope_scoreboard;
		logic [LEN_W-1:0]   attack_len;
		logic [LEN_W-1:0]   decay_len;
		logic [SUS_W-1:0]   sustain_lvl;
		logic [LEN_W-1:0]   release_len;
		logic [STEP_W-1:0]  step_len;
		phase_t             cur_phase;
		logic [63:0]        elapsed;
		logic [LEVEL_W-1:0] cur_level;
		env_word_t          expected_words[$];
		int                 fails;

		function new();
			attack_len  = RST_ATTACK;
			decay_len   = RST_DECAY;
			sustain_lvl = RST_SUSTAIN;
			release_len = RST_RELEASE;
			step_len    = RST_STEP;
			cur_phase   = PH_ATTACK;
			elapsed     = 64'd0;
			cur_level   = '0;
			fails       = 0;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		// accepted register write; indexes past the list are ignored
		function void set_reg(cfg_idx_t idx, logic [LEN_W-1:0] data);
			case (idx)
				REG_ATTACK:  attack_len = data;
				REG_DECAY:   decay_len = data;
				REG_SUSTAIN: sustain_lvl = data[SUS_W-1:0];
				REG_RELEASE: release_len = data;
				REG_STEP:    step_len = data[STEP_W-1:0];
				default: ;
			endcase
		endfunction

		// one tick: level from phase and elapsed with fall-through, then advance elapsed
		function void advance_envelope();
			logic [63:0] one;
			logic [63:0] sus;
			logic [63:0] e;
			logic [63:0] lvl;
			logic [63:0] a64;
			logic [63:0] d64;
			logic [63:0] r64;
			bit          settled;
			one = 64'd1 << FRAC_BITS;
			sus = (64'(sustain_lvl) > one) ? one : 64'(sustain_lvl);
			e = elapsed;
			lvl = 64'd0;
			a64 = 64'(attack_len);
			d64 = 64'(decay_len);
			r64 = 64'(release_len);
			settled = 1'b0;
			if (cur_phase == PH_ATTACK) begin
				if (e < a64) begin
					lvl = (e * one) / a64;
					settled = 1'b1;
				end else begin
					e = e - a64;
					cur_phase = PH_DECAY;
				end
			end
			if (!settled && cur_phase == PH_DECAY) begin
				if (e < d64) begin
					lvl = one - ((one - sus) * e) / d64;
					settled = 1'b1;
				end else begin
					e = e - d64;
					cur_phase = PH_SUSTAIN;
				end
			end
			if (!settled) begin
				if (cur_phase == PH_SUSTAIN) begin
					lvl = sus;
				end else if (e < r64) begin
					lvl = sus - (sus * e) / r64;
				end else begin
					lvl = 64'd0;
				end
			end
			cur_level = lvl[LEVEL_W-1:0];
			e = e + 64'(step_len);
			if (e > ELAPSED_MAX)
				e = ELAPSED_MAX;
			elapsed = e;
		endfunction

		// accepted event word: update state and queue the result it causes
		function void note_event(mode_t mode, phase_t rp);
			env_word_t w;
			case (mode)
				MODE_TICK: advance_envelope();
				MODE_NOTEOFF: begin
					if (cur_phase != PH_RELEASE) begin
						elapsed = 64'd0;
						cur_phase = PH_RELEASE;
					end
				end
				MODE_RESTART: begin
					elapsed = 64'd0;
					cur_phase = rp;
				end
				default: ;
			endcase
			w.level = cur_level;
			w.phase = cur_phase;
			w.released = (cur_phase == PH_RELEASE) && (64'(release_len) <= elapsed);
			expected_words.push_back(w);
		endfunction

		// print is capped so a broken block cannot flood the log; every mismatch counts
		task report(string what);
			if (fails < 40)
				$display("mismatch: %s", what);
			fails++;
		endtask

		task check_result(logic [23:0] word);
			env_word_t got;
			env_word_t want;
			got = word[18:0];
			if (expected_words.size() == 0) begin
				report($sformatf("result word %h with none expected", word));
			end else begin
				want = expected_words.pop_front();
				if (got.level !== want.level)
					report($sformatf("level %0d, expected %0d", got.level, want.level));
				if (got.phase !== want.phase)
					report($sformatf("phase %0d, expected %0d", got.phase, want.phase));
				if (got.released !== want.released)
					report($sformatf("released %b, expected %b", got.released,
						want.released));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;    // [1:0] restart_phase
	logic [1:0]           s_axis_tuser = '0;    // [1:0] mode
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;         // [15:0] level, [17:16] phase, [18] released
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEN_W-1:0]     cfg_data = '0;

	envelope_scoreboard sb = new();
	int  events_sent = 0;
	int  tx_gap = 0;
	int  rx_wait = 0;
	bit  quiet = 1'b0;

	adsr_envelope_generator #(
		.LEVEL_FRAC_BITS(FRAC_BITS),
		.TIME_BITS(TIME_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 4);
	endfunction

	// result side: check each accepted word, then stall for a drawn number of cycles
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata);
			rx_wait = draw_wait();
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		m_axis_tready <= (rx_wait == 0);
	end

	// watchdog on cycles with no word moving on any channel
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL");
		$finish;
	end

	// send one event word; the gap before the next word is drawn at acceptance
	task automatic send_event(input mode_t m, input phase_t rp);
		if (tx_gap > 0)
			repeat (tx_gap) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= m;
		s_axis_tdata <= {6'b0, rp};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_event(m, rp);
		events_sent++;
		tx_gap = draw_wait();
		if (tx_gap > 0)
			s_axis_tvalid <= 1'b0;
	endtask

	task automatic send_tick();
		send_event(MODE_TICK, phase_t'($urandom));
	endtask

	// stop sending and wait for every expected word
	task automatic drain();
		if (tx_gap == 0) begin
			s_axis_tvalid <= 1'b0;
			tx_gap = 1;
		end
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// valid stays high across back-to-back writes; the caller lowers it
	task automatic write_reg(input cfg_idx_t idx, input logic [LEN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	// full register set, upper bits of the narrow registers random, optional unused indexes
	task automatic apply_settings(input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] d,
		input logic [SUS_W-1:0] s, input logic [LEN_W-1:0] r, input logic [STEP_W-1:0] st,
		input bit junk);
		int k;
		drain();
		write_reg(REG_ATTACK, a);
		write_reg(REG_DECAY, d);
		write_reg(REG_SUSTAIN, {8'($urandom), s});
		write_reg(REG_RELEASE, r);
		write_reg(REG_STEP, {8'($urandom), st});
		if (junk) begin
			for (k = 1; k <= 3; k++)
				write_reg(cfg_idx_t'(REG_STEP + k), LEN_W'($urandom));
		end
		cfg_valid <= 1'b0;
	endtask

	// well-formed note: restart in attack, ticks, note off, ticks in release
	task automatic play_note();
		send_event(MODE_RESTART, PH_ATTACK);
		repeat ($urandom_range(4, 30)) send_tick();
		send_event(MODE_NOTEOFF, phase_t'($urandom));
		repeat ($urandom_range(2, 25)) send_tick();
	endtask

	task automatic run_random(input int budget);
		int target;
		int pick;
		target = events_sent + budget;
		while (events_sent < target) begin
			pick = $urandom_range(0, 9);
			quiet = ($urandom_range(0, 7) == 0);
			if (pick < 6) begin
				play_note();
			end else if (pick < 8) begin
				send_event(MODE_RESTART, phase_t'($urandom));
				repeat ($urandom_range(1, 15)) send_tick();
			end else begin
				repeat ($urandom_range(1, 3))
					send_event(mode_t'($urandom), phase_t'($urandom));
			end
		end
		quiet = 1'b0;
	endtask

	function automatic logic [LEN_W-1:0] rand_len();
		return ($urandom_range(0, 9) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 1500));
	endfunction

	initial begin : stimulus
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, every event kind, note off while releasing
		send_tick();
		send_tick();
		send_tick();
		send_event(MODE_IDLE, PH_RELEASE);
		send_event(MODE_NOTEOFF, PH_ATTACK);
		send_event(MODE_NOTEOFF, PH_RELEASE);
		send_tick();
		send_event(MODE_RESTART, PH_DECAY);
		send_tick();
		send_event(MODE_RESTART, PH_SUSTAIN);
		send_tick();
		send_event(MODE_RESTART, PH_RELEASE);
		send_tick();
		send_event(MODE_RESTART, PH_ATTACK);
		send_tick();
		send_event(MODE_IDLE, PH_ATTACK);

		// short phases so notes run through all four
		apply_settings(24'd300, 24'd500, 16'd16384, 24'd800, 16'd40, 1'b1);
		run_random(85);

		// zero-length phases are skipped, full-scale sustain
		apply_settings('0, '0, 16'd32768, '0, 16'd1, 1'b0);
		send_event(MODE_RESTART, PH_ATTACK);
		send_tick();
		send_event(MODE_NOTEOFF, PH_DECAY);
		send_tick();
		run_random(80);

		// largest lengths and step, sustain above full scale; a long release saturates
		// elapsed, which is the only way to reach the end of a full-length release
		apply_settings(LEN_MAX, LEN_MAX, 16'hFFFF, LEN_MAX, 16'hFFFF, 1'b0);
		quiet = 1'b1;
		send_event(MODE_RESTART, PH_ATTACK);
		repeat (20) send_tick();
		send_event(MODE_RESTART, PH_RELEASE);
		repeat (260) send_tick();
		send_event(MODE_NOTEOFF, PH_SUSTAIN);
		repeat (2) send_tick();
		quiet = 1'b0;
		run_random(20);

		// one-unit phases, zero sustain, elapsed frozen
		apply_settings(24'd1, 24'd1, 16'd0, 24'd1, 16'd0, 1'b0);
		run_random(80);

		// step larger than all phases together: several fall-throughs per tick
		apply_settings(24'd100, 24'd200, 16'd1000, 24'd300, 16'hFFFF, 1'b1);
		run_random(80);

		// random settings
		for (n = 0; n < 3; n++) begin
			apply_settings(rand_len(), rand_len(),
				($urandom_range(0, 3) == 0) ? SUS_W'($urandom) : SUS_W'($urandom_range(0, 32768)),
				rand_len(), STEP_W'($urandom_range(0, 300)), n[0]);
			run_random(85);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
